// File: sv/pba_pkg.sv
// shared types and constants of the part bitmap allocator
package pba_pkg;

  localparam int MAX_PARTS = 256;
  localparam int WORD_W    = 16;
  localparam int WORD_BITS = 4;
  localparam int MODE_W    = 2;
  localparam int PART_W    = 9;
  localparam int PCT_W     = 7;
  localparam int REM_W     = 16;
  localparam int STEP_W    = 3;

  localparam logic [PART_W-1:0] NUM_PARTS_RST = 9'd256;
  localparam logic [PCT_W-1:0]  PCT_FULL      = 7'd100;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLAIM   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_DONE    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_RMW_RD = 8'b0000_1000,
    ST_RMW_WR = 8'b0001_0000,
    ST_COPY   = 8'b0010_0000,
    ST_LOAD   = 8'b0100_0000,
    ST_DIV    = 8'b1000_0000
  } state_t;

endpackage

// File: sv/part_bitmap_allocator.sv
// part bitmap allocator: claim and done bitmaps in ram, iterative percentage divider
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+----------------------------
//  in      | in_mode, in_part                       | start while busy is low
//  out     | out_part_number, out_percent, out_status| out_valid, one cycle
//  cfg     | cfg_wdata                              | cfg_we, no wait
//
// one word at a time; ram words hold W = 16 parts:
//   claim scans up to ceil(num_parts/16) words, with num_parts clamped to 1..MAX_PARTS
//   release and done read-modify-write one word, out of range skips the ram, restart copies done ram to claim ram
//   the percentage comes from a shift-subtract divider
// after reset both rams are cleared with busy high
// results cannot be stalled; out_valid pulses in the cycle busy falls
module part_bitmap_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [pba_pkg::MODE_W-1:0]  in_mode,
  input  logic [pba_pkg::PART_W-1:0]  in_part,
  output logic                        out_valid,
  output logic [pba_pkg::PART_W-1:0]  out_part_number,
  output logic [pba_pkg::PCT_W-1:0]   out_percent,
  output logic                        out_status,
  input  logic                        cfg_we,
  input  logic [pba_pkg::PART_W-1:0]  cfg_wdata
);

  import pba_pkg::*;

  localparam int DEPTH = (MAX_PARTS + WORD_W - 1) / WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t               state_r, state_nxt;
  mode_t                mode_r, mode_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [AW-1:0]        chk_addr_r, chk_addr_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [WORD_BITS-1:0] bit_r, bit_nxt;
  logic [PART_W-1:0]    num_parts_r;
  logic [PART_W-1:0]    count_r, count_nxt;
  logic [PART_W-1:0]    pnum_r, pnum_nxt;
  logic                 status_r, status_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [PCT_W-1:0]     quo_r, quo_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 sat_r, sat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PART_W-1:0]    out_part_number_r;
  logic [PCT_W-1:0]     out_percent_r, out_percent_nxt;
  logic                 out_status_r;

  logic [PART_W-1:0]    eff_n, nm1, in_idx;
  logic [AW-1:0]        last_word;
  logic [WORD_BITS-1:0] last_bit;
  logic                 in_ok;
  logic                 claim_we, done_we;
  logic [AW-1:0]        wr_addr;
  logic [WORD_W-1:0]    claim_wdata, done_wdata, claim_rdata, done_rdata;
  logic [WORD_W-1:0]    scan_word, bit_sel;
  logic                 found;
  logic [WORD_BITS-1:0] fz_bit;
  logic [REM_W-1:0]     dvs;

  pba_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_claim_ram (
    .clk   (clk),
    .we    (claim_we),
    .waddr (wr_addr),
    .wdata (claim_wdata),
    .raddr (addr_r),
    .rdata (claim_rdata)
  );

  pba_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_done_ram (
    .clk   (clk),
    .we    (done_we),
    .waddr (wr_addr),
    .wdata (done_wdata),
    .raddr (addr_r),
    .rdata (done_rdata)
  );

  always_comb begin
    if (num_parts_r == '0) begin
      eff_n = PART_W'(1);
    end else if (32'(num_parts_r) > MAX_PARTS) begin
      eff_n = PART_W'(MAX_PARTS);
    end else begin
      eff_n = num_parts_r;
    end
  end

  assign nm1       = eff_n - PART_W'(1);
  assign last_word = AW'(nm1 >> WORD_BITS);
  assign last_bit  = nm1[WORD_BITS-1:0];
  assign in_idx    = in_part - PART_W'(1);
  assign in_ok     = (in_part != '0) && (in_part <= eff_n);
  assign bit_sel   = WORD_W'(1) << bit_r;
  assign dvs       = REM_W'(eff_n) << step_r;

  // parts past the last one in use count as claimed
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      scan_word[b] = claim_rdata[b] |
                     ((chk_addr_r == last_word) && (WORD_BITS'(b) > last_bit));
    end
  end

  always_comb begin
    found  = 1'b0;
    fz_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        found  = 1'b1;
        fz_bit = WORD_BITS'(b);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    addr_nxt        = addr_r;
    chk_addr_nxt    = chk_addr_r;
    chk_vld_nxt     = chk_vld_r;
    bit_nxt         = bit_r;
    count_nxt       = count_r;
    pnum_nxt        = pnum_r;
    status_nxt      = status_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    step_nxt        = step_r;
    sat_nxt         = sat_r;
    out_valid_nxt   = 1'b0;
    out_percent_nxt = out_percent_r;
    claim_we        = 1'b0;
    done_we         = 1'b0;
    wr_addr         = addr_r;
    claim_wdata     = '0;
    done_wdata      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        claim_we = 1'b1;
        done_we  = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(DEPTH - 1)) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          mode_nxt    = mode_t'(in_mode);
          bit_nxt     = in_idx[WORD_BITS-1:0];
          chk_vld_nxt = 1'b0;
          pnum_nxt    = '0;
          status_nxt  = 1'b0;
          unique case (mode_t'(in_mode))
            MODE_CLAIM: begin
              addr_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            MODE_RELEASE, MODE_DONE: begin
              if (in_ok) begin
                addr_nxt  = AW'(in_idx >> WORD_BITS);
                state_nxt = ST_RMW_RD;
              end else begin
                status_nxt = 1'b1;
                state_nxt  = ST_LOAD;
              end
            end
            MODE_RESTART: begin
              addr_nxt  = '0;
              state_nxt = ST_COPY;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        addr_nxt     = addr_r + AW'(1);
        chk_addr_nxt = addr_r;
        chk_vld_nxt  = 1'b1;
        if (chk_vld_r) begin
          if (found) begin
            claim_we    = 1'b1;
            wr_addr     = chk_addr_r;
            claim_wdata = claim_rdata | (WORD_W'(1) << fz_bit);
            pnum_nxt    = PART_W'({chk_addr_r, fz_bit}) + PART_W'(1);
            state_nxt   = ST_LOAD;
          end else if (chk_addr_r == last_word) begin
            status_nxt = 1'b1;
            state_nxt  = ST_LOAD;
          end
        end
      end

      ST_RMW_RD: begin
        state_nxt = ST_RMW_WR;
      end

      ST_RMW_WR: begin
        if (mode_r == MODE_RELEASE) begin
          claim_we    = 1'b1;
          claim_wdata = claim_rdata & ~bit_sel;
        end else begin
          done_we    = 1'b1;
          done_wdata = done_rdata | bit_sel;
          if (!done_rdata[bit_r]) begin
            count_nxt = count_r + PART_W'(1);
          end
        end
        state_nxt = ST_LOAD;
      end

      ST_COPY: begin
        addr_nxt     = addr_r + AW'(1);
        chk_addr_nxt = addr_r;
        chk_vld_nxt  = 1'b1;
        if (chk_vld_r) begin
          claim_we    = 1'b1;
          wr_addr     = chk_addr_r;
          claim_wdata = done_rdata;
          if (chk_addr_r == AW'(DEPTH - 1)) begin
            state_nxt = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        rem_nxt   = REM_W'(count_r) * REM_W'(PCT_FULL);
        quo_nxt   = '0;
        step_nxt  = STEP_W'(PCT_W - 1);
        sat_nxt   = (count_r >= eff_n);
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (rem_r >= dvs) begin
          rem_nxt         = rem_r - dvs;
          quo_nxt[step_r] = 1'b1;
        end
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          out_valid_nxt   = 1'b1;
          out_percent_nxt = sat_r ? PCT_FULL : quo_nxt;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      chk_vld_r   <= 1'b0;
      num_parts_r <= NUM_PARTS_RST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        num_parts_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    chk_addr_r    <= chk_addr_nxt;
    bit_r         <= bit_nxt;
    pnum_r        <= pnum_nxt;
    status_r      <= status_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    step_r        <= step_nxt;
    sat_r         <= sat_nxt;
    out_percent_r <= out_percent_nxt;
    if (out_valid_nxt) begin
      out_part_number_r <= pnum_r;
      out_status_r      <= status_r;
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_part_number = out_part_number_r;
  assign out_percent     = out_percent_r;
  assign out_status      = out_status_r;

endmodule

// File: sv/pba_ram.sv
// generic single-port-write ram with registered read
module pba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sim/part_bitmap_allocator_test.sv
// testbench for the part bitmap allocator: directed and random commands checked against a predictor
module part_bitmap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  localparam int PARTS_MAX   = 256;
  localparam int WORDS_PLAN  = 1400;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_PHASES  = 12;

  typedef struct packed {
    mode_t             mode;
    logic [PART_W-1:0] part;
  } part_cmd_t;

  typedef struct packed {
    logic [PART_W-1:0] part_number;
    logic [PCT_W-1:0]  percent;
    logic              status;
  } alloc_reply_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  logic [MODE_W-1:0] in_mode   = '0;
  logic [PART_W-1:0] in_part   = '0;
  logic              out_valid;
  logic [PART_W-1:0] out_part_number;
  logic [PCT_W-1:0]  out_percent;
  logic              out_status;
  logic              cfg_we    = 1'b0;
  logic [PART_W-1:0] cfg_wdata = '0;

  part_cmd_t    cmd_q[$];
  alloc_reply_t reply_q[$];

  logic [PARTS_MAX-1:0] claimed_bits = '0;
  logic [PARTS_MAX-1:0] done_bits    = '0;
  int unsigned          done_total   = 0;
  logic [PART_W-1:0]    parts_cfg    = NUM_PARTS_RST;

  int unsigned words_sent   = 0;
  int unsigned words_in     = 0;
  int unsigned replies_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned settings_run = 0;
  int unsigned quiet_cycles = 0;

  part_bitmap_allocator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_part         (in_part),
    .out_valid       (out_valid),
    .out_part_number (out_part_number),
    .out_percent     (out_percent),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int unsigned usable_parts(input logic [PART_W-1:0] v);
    if (v == 0) return 1;
    if (v > PARTS_MAX) return PARTS_MAX;
    return 32'(v);
  endfunction

  function automatic alloc_reply_t allocate_step(input logic [MODE_W-1:0] mode,
                                                 input logic [PART_W-1:0] part);
    alloc_reply_t r;
    int unsigned  n;
    int unsigned  i;
    int unsigned  pct;
    n = usable_parts(parts_cfg);
    r.part_number = '0;
    r.status = 1'b0;
    case (mode)
      MODE_CLAIM: begin
        r.status = 1'b1;
        for (i = 0; i < n && r.status; i++) begin
          if (!claimed_bits[i]) begin
            claimed_bits[i] = 1'b1;
            r.part_number = PART_W'(i + 1);
            r.status = 1'b0;
          end
        end
      end
      MODE_RELEASE: begin
        if (part >= 1 && part <= n) claimed_bits[part-1] = 1'b0;
        else r.status = 1'b1;
      end
      MODE_DONE: begin
        if (part >= 1 && part <= n) begin
          if (!done_bits[part-1]) begin
            done_bits[part-1] = 1'b1;
            done_total++;
          end
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        claimed_bits = done_bits;
      end
    endcase
    pct = done_total * 100 / n;
    if (pct > 100) pct = 100;
    r.percent = pct[PCT_W-1:0];
    return r;
  endfunction

  function automatic part_cmd_t random_cmd(input int unsigned n);
    part_cmd_t   c;
    int unsigned sel;
    sel = $urandom_range(99);
    c.part = PART_W'($urandom_range(511));
    if (sel < 8) begin
      c.mode = mode_t'($urandom_range(3));
    end else if (sel < 12) begin
      c.mode = mode_t'($urandom_range(1, 2));
      c.part = PART_W'($urandom_range(1) ? 0 : n + 1);
    end else if (sel < 50) begin
      c.mode = MODE_CLAIM;
    end else if (sel < 68) begin
      c.mode = MODE_RELEASE;
      c.part = PART_W'($urandom_range(1, n));
    end else if (sel < 96) begin
      c.mode = MODE_DONE;
      c.part = PART_W'($urandom_range(1, n));
    end else begin
      c.mode = MODE_RESTART;
    end
    return c;
  endfunction

  task automatic push_cmd(input mode_t mode, input int unsigned part);
    part_cmd_t c;
    c.mode = mode;
    c.part = part[PART_W-1:0];
    cmd_q.push_back(c);
  endtask

  task automatic push_random(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) cmd_q.push_back(random_cmd(usable_parts(parts_cfg)));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_q.size() != 0 || start || busy !== 1'b0 || reply_q.size() != 0);
  endtask

  task automatic write_num_parts(input logic [PART_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    parts_cfg = v;
    settings_run++;
  endtask

  task automatic note_mismatch(input string what, input alloc_reply_t want,
                               input alloc_reply_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected part %0d pct %0d status %0d, got part %0d pct %0d status %0d",
               $time, what, want.part_number, want.percent, want.status,
               got.part_number, got.percent, got.status);
  endtask

  // driver
  always @(posedge clk) begin
    part_cmd_t   next_cmd;
    int unsigned gap_pct;
    gap_pct = (words_sent < WORDS_PLAN / 3) ? 12 : (words_sent < 2 * WORDS_PLAN / 3) ? 49 : 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) words_sent++;
      if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        next_cmd = cmd_q.pop_front();
        start   <= 1'b1;
        in_mode <= next_cmd.mode;
        in_part <= next_cmd.part;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    alloc_reply_t want;
    alloc_reply_t got;
    if (rst_n) begin
      if (out_valid) begin
        replies_seen++;
        got.part_number = out_part_number;
        got.percent     = out_percent;
        got.status      = out_status;
        if (reply_q.size() == 0) begin
          note_mismatch("unexpected word", '0, got);
        end else begin
          want = reply_q.pop_front();
          if (got.part_number !== want.part_number || got.percent !== want.percent ||
              got.status !== want.status)
            note_mismatch("mismatch", want, got);
        end
      end
      if (start && !busy) begin
        words_in++;
        reply_q.push_back(allocate_step(in_mode, in_part));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no word accepted", STALL_LIMIT);
      $display("part_bitmap_allocator_test: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned        p;
    logic [PART_W-1:0]  phase_parts [NUM_PHASES];
    int unsigned        phase_len   [NUM_PHASES];
    phase_parts = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd8, 9'd17, 9'd40, 9'd100, 9'd255, 9'd256,
                    9'd511, 9'd5};
    phase_len   = '{60, 60, 60, 80, 120, 120, 150, 150, 180, 150, 150, 80};

    // reset value of num_parts
    push_random(40);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_num_parts(9'd4);
    push_cmd(MODE_CLAIM, 0);
    push_cmd(MODE_CLAIM, 0);
    push_cmd(MODE_CLAIM, 0);
    push_cmd(MODE_CLAIM, 0);
    push_cmd(MODE_CLAIM, 0);
    push_cmd(MODE_RELEASE, 0);
    push_cmd(MODE_RELEASE, 5);
    push_cmd(MODE_RELEASE, 511);
    push_cmd(MODE_RELEASE, 2);
    push_cmd(MODE_CLAIM, 0);
    push_cmd(MODE_DONE, 1);
    push_cmd(MODE_DONE, 1);
    push_cmd(MODE_DONE, 0);
    push_cmd(MODE_DONE, 511);
    push_cmd(MODE_DONE, 4);
    push_cmd(MODE_RESTART, 0);
    push_cmd(MODE_CLAIM, 0);
    push_cmd(MODE_CLAIM, 0);
    push_cmd(MODE_DONE, 2);
    push_cmd(MODE_DONE, 3);
    push_cmd(MODE_CLAIM, 511);
    push_cmd(MODE_RESTART, 256);
    push_cmd(MODE_RELEASE, 4);

    for (p = 0; p < NUM_PHASES; p++) begin
      write_num_parts(phase_parts[p]);
      push_random(phase_len[p]);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("%0d commands over %0d num_parts settings, %0d replies checked, %0d mismatches",
             words_in, settings_run, replies_seen, mismatches);
    $display("final state: %0d parts done", done_total);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("part_bitmap_allocator_test: PASS");
    end else begin
      $display("part_bitmap_allocator_test: FAIL");
    end
    $finish;
  end

endmodule
